@@ rtl/assert_macros.svh @@
// Assertion macros shared by the text cell buffer RTL.
// Each macro expects signals named clk and rst in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define TCB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Condition that must never be true outside reset.
`define TCB_ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error(msg);

`endif

@@ rtl/tcb_pkg.sv @@
// Package for the text cell buffer: command codes, characters, mode limits,
// controller states and the command/status structs. No dependencies.
package tcb_pkg;

  localparam logic [1:0] CMD_PUT   = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  localparam logic [7:0] CH_NEWLINE   = 8'd10;
  localparam logic [7:0] CH_BACKSPACE = 8'd8;

  // Screen size in the small mode, before capping at the store size.
  localparam int SMALL_COLS = 45;
  localparam int SMALL_ROWS = 25;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_RUN,
    S_READ
  } tcb_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;   // execute the item on the input ports now
    logic clr_en;   // zero one cell of the clearing pass and step on
    logic rd_load;  // capture the read data into the result register
  } tcb_ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_valid;  // result register holds an untaken result
    logic is_read;    // the offered item is a read
    logic clears;     // the offered item clears the whole store
    logic clr_last;   // the clearing pass is at its final cell
  } tcb_stat_t;

endpackage

@@ rtl/tcb_ctrl.sv @@
// Controller state machine of the text cell buffer.
// Depends on tcb_pkg for the state type and the command/status structs.
module tcb_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              out_ready,
  input  tcb_pkg::tcb_stat_t stat,
  output logic              in_ready,
  output tcb_pkg::tcb_ctl_t  ctl
);

  tcb_pkg::tcb_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tcb_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    in_ready    = 1'b0;
    ctl.accept  = 1'b0;
    ctl.clr_en  = 1'b0;
    ctl.rd_load = 1'b0;
    case (state)
      tcb_pkg::S_CLEAR: begin
        ctl.clr_en = 1'b1;
        if (stat.clr_last) begin
          state_next = tcb_pkg::S_RUN;
        end
      end
      tcb_pkg::S_RUN: begin
        // A new item may enter as the waiting result leaves.
        in_ready = !stat.out_valid || out_ready;
        if (in_valid && in_ready) begin
          ctl.accept = 1'b1;
          if (stat.is_read) begin
            state_next = tcb_pkg::S_READ;
          end else if (stat.clears) begin
            state_next = tcb_pkg::S_CLEAR;
          end
        end
      end
      tcb_pkg::S_READ: begin
        ctl.rd_load = 1'b1;
        state_next  = tcb_pkg::S_RUN;
      end
      default: begin
        state_next = tcb_pkg::S_CLEAR;
      end
    endcase
  end

endmodule

@@ rtl/tcb_datapath.sv @@
// Datapath of the text cell buffer: cursor, cell memory, clearing counter
// and result register. Depends on tcb_pkg and assert_macros.svh.
`include "assert_macros.svh"

module tcb_datapath #(
  parameter int ROWS_MAX = 75,
  parameter int COLS_MAX = 100
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               gui_mode,
  input  tcb_pkg::tcb_ctl_t  ctl,
  input  logic [1:0]         cmd,
  input  logic [7:0]         char_code,
  input  logic [6:0]         read_row,
  input  logic [6:0]         read_col,
  input  logic               out_ready,
  output tcb_pkg::tcb_stat_t stat,
  output logic               out_valid,
  output logic [7:0]         cell_char,
  output logic [6:0]         cursor_col,
  output logic [6:0]         cursor_row,
  output logic               screen_cleared
);

  localparam int DEPTH = ROWS_MAX * COLS_MAX;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int COL_SMALL =
    (tcb_pkg::SMALL_COLS < COLS_MAX) ? tcb_pkg::SMALL_COLS : COLS_MAX;
  localparam int ROW_SMALL =
    (tcb_pkg::SMALL_ROWS < ROWS_MAX) ? tcb_pkg::SMALL_ROWS : ROWS_MAX;

  logic [6:0]    cur_col;
  logic [6:0]    cur_row;
  logic [6:0]    col_next;
  logic [6:0]    row_next;
  logic [AW-1:0] clr_cnt;
  logic          in_range;
  logic          in_range_q;
  logic [7:0]    mem [DEPTH];
  logic [7:0]    rdata;

  logic          is_put;
  logic          is_nl;
  logic          is_bs;
  logic          is_plain;
  logic          is_clear;
  logic [7:0]    col_inc;
  logic [7:0]    row_inc;
  logic [7:0]    col_lim;
  logic [7:0]    row_lim;
  logic          col_wrap;
  logic          row_step;
  logic          row_over;
  logic          item_clears;
  logic          item_wr;
  logic [6:0]    row_sel;
  logic [6:0]    col_sel;
  logic [14:0]   addr_full;
  logic [AW-1:0] mem_addr;
  logic          mem_we;
  logic [7:0]    mem_wdata;
  logic          cursor_in_store;

  // Item decode and cursor arithmetic.
  always_comb begin
    is_put   = 1'b0;
    is_clear = 1'b0;
    case (cmd)
      tcb_pkg::CMD_PUT:   is_put   = 1'b1;
      tcb_pkg::CMD_CLEAR: is_clear = 1'b1;
      default: ;
    endcase
    is_nl    = is_put && (char_code == tcb_pkg::CH_NEWLINE);
    is_bs    = is_put && (char_code == tcb_pkg::CH_BACKSPACE);
    is_plain = is_put && !is_nl && !is_bs;

    col_lim  = gui_mode ? 8'(COL_SMALL) : 8'(COLS_MAX);
    row_lim  = gui_mode ? 8'(ROW_SMALL) : 8'(ROWS_MAX);
    col_inc  = {1'b0, cur_col} + 8'd1;
    row_inc  = {1'b0, cur_row} + 8'd1;
    col_wrap = col_inc >= col_lim;
    row_step = is_nl || (is_plain && col_wrap);
    row_over = row_inc >= row_lim;
    item_clears = is_clear || (row_step && row_over);

    col_next = cur_col;
    row_next = cur_row;
    if (item_clears) begin
      col_next = '0;
      row_next = '0;
    end else if (row_step) begin
      col_next = '0;
      row_next = row_inc[6:0];
    end else if (is_plain) begin
      col_next = col_inc[6:0];
    end else if (is_bs && (cur_col != 7'd0)) begin
      col_next = cur_col - 7'd1;
    end

    item_wr  = is_plain || (is_bs && (cur_col != 7'd0));
    in_range = ({1'b0, read_row} < 8'(ROWS_MAX)) && ({1'b0, read_col} < 8'(COLS_MAX));
  end

  // Cell address: the cursor cell (one to the left for backspace) or the
  // requested cell of a read.
  always_comb begin
    row_sel = cur_row;
    col_sel = is_bs ? (cur_col - 7'd1) : cur_col;
    if (stat.is_read) begin
      row_sel = read_row;
      col_sel = read_col;
    end
    addr_full = 15'(row_sel) * 15'(COLS_MAX) + 15'(col_sel);
    mem_addr  = ctl.clr_en ? clr_cnt : addr_full[AW-1:0];
    mem_we    = ctl.clr_en || (ctl.accept && item_wr);
    mem_wdata = (ctl.clr_en || is_bs) ? 8'd0 : char_code;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    rdata <= mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_col <= '0;
      cur_row <= '0;
      clr_cnt <= '0;
    end else begin
      if (ctl.accept) begin
        cur_col <= col_next;
        cur_row <= row_next;
      end
      if (ctl.accept && item_clears) begin
        clr_cnt <= '0;
      end else if (ctl.clr_en) begin
        clr_cnt <= clr_cnt + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((ctl.accept && !stat.is_read) || ctl.rd_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      in_range_q <= in_range;
    end
    if (ctl.accept && !stat.is_read) begin
      cell_char      <= 8'd0;
      cursor_col     <= col_next;
      cursor_row     <= row_next;
      screen_cleared <= item_clears;
    end else if (ctl.rd_load) begin
      cell_char      <= in_range_q ? rdata : 8'd0;
      cursor_col     <= cur_col;
      cursor_row     <= cur_row;
      screen_cleared <= 1'b0;
    end
  end

  assign stat.out_valid = out_valid;
  assign stat.is_read   = (cmd == tcb_pkg::CMD_READ);
  assign stat.clears    = item_clears;
  assign stat.clr_last  = (clr_cnt == AW'(DEPTH - 1));

  assign cursor_in_store = ({1'b0, cur_col} < 8'(COLS_MAX)) &&
                           ({1'b0, cur_row} < 8'(ROWS_MAX));

  `TCB_ASSERT(a_result_after_item, (ctl.accept && !stat.is_read) |=> out_valid, "no result after item")
  `TCB_ASSERT_NEVER(a_read_over_result, ctl.rd_load && out_valid, "read data overwrites a result")
  `TCB_ASSERT(a_cursor_in_store, cursor_in_store, "cursor outside the cell store")
  `TCB_ASSERT_NEVER(a_item_during_clear, ctl.accept && ctl.clr_en, "item taken during clearing pass")

endmodule

@@ rtl/text_cell_buffer_cursor.sv @@
// Top level of the text cell buffer with cursor: mode register and the
// controller and datapath. Depends on tcb_pkg, tcb_ctrl and tcb_datapath.
//
//   Channel  Direction  Handshake              Payload
//   in       input      in_valid / in_ready    cmd, char_code, read_row, read_col
//   out      output     out_valid / out_ready  cell_char, cursor_col, cursor_row,
//                                              screen_cleared
//   cfg      input      cfg_we (no wait)       cfg_wdata -> gui_mode
//
// A read passes the read state, as the cell memory has a registered read port
// and the data lands in the cycle after the address. A new item enters in
// the cycle its predecessor's result is taken. After reset, and after any
// item that clears the screen, the block zeroes the cell memory one cell per
// cycle, over all ROWS_MAX * COLS_MAX cells (7500 by default), and accepts no
// item meanwhile; the clearing result itself is delivered at once. A stalled
// output holds its result and blocks input.
module text_cell_buffer_cursor #(
  parameter int ROWS_MAX = 75,
  parameter int COLS_MAX = 100
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_wdata,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] cmd,
  input  logic [7:0] char_code,
  input  logic [6:0] read_row,
  input  logic [6:0] read_col,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] cell_char,
  output logic [6:0] cursor_col,
  output logic [6:0] cursor_row,
  output logic       screen_cleared
);

  // Mode register: 0 selects the full screen, 1 the small screen. A write
  // does not clear; software is to follow it with a clear command.
  logic gui_mode;

  tcb_pkg::tcb_ctl_t  ctl;
  tcb_pkg::tcb_stat_t stat;

  always_ff @(posedge clk) begin
    if (rst) begin
      gui_mode <= 1'b0;
    end else if (cfg_we) begin
      gui_mode <= cfg_wdata;
    end
  end

  // The controller sequences the clearing pass, item execution and the
  // read wait; the datapath owns the cursor, the cell memory and the result.
  tcb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .in_ready  (in_ready),
    .ctl       (ctl)
  );

  tcb_datapath #(
    .ROWS_MAX (ROWS_MAX),
    .COLS_MAX (COLS_MAX)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .gui_mode       (gui_mode),
    .ctl            (ctl),
    .cmd            (cmd),
    .char_code      (char_code),
    .read_row       (read_row),
    .read_col       (read_col),
    .out_ready      (out_ready),
    .stat           (stat),
    .out_valid      (out_valid),
    .cell_char      (cell_char),
    .cursor_col     (cursor_col),
    .cursor_row     (cursor_row),
    .screen_cleared (screen_cleared)
  );

endmodule

@@ tb/text_cell_buffer_cursor_checker.sv @@
`timescale 1ns / 1ps
// Checker for the text cell buffer: watches the item, result and mode ports,
// keeps its own copy of the cell store and cursor, and compares each result.
// Depends on tcb_pkg for the command codes, control characters and mode sizes.
module text_cell_buffer_cursor_checker #(
  parameter int ROWS_MAX = 75,
  parameter int COLS_MAX = 100
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_wdata,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [1:0] cmd,
  input  logic [7:0] char_code,
  input  logic [6:0] read_row,
  input  logic [6:0] read_col,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [7:0] cell_char,
  input  logic [6:0] cursor_col,
  input  logic [6:0] cursor_row,
  input  logic       screen_cleared,
  output int         mismatch_count,
  output int         results_pending
);

  typedef struct packed {
    logic [7:0] cell_char;
    logic [6:0] cursor_col;
    logic [6:0] cursor_row;
    logic       screen_cleared;
  } cell_result_t;

  logic [7:0]   shadow_cells [ROWS_MAX * COLS_MAX];
  int           cur_col;
  int           cur_row;
  logic         narrow_mode;
  cell_result_t expected_results [$];
  int           errors;
  int           pending;

  assign mismatch_count  = errors;
  assign results_pending = pending;

  initial begin
    errors  = 0;
    pending = 0;
  end

  function automatic int col_limit();
    if (narrow_mode) begin
      return (tcb_pkg::SMALL_COLS < COLS_MAX) ? tcb_pkg::SMALL_COLS : COLS_MAX;
    end
    return COLS_MAX;
  endfunction

  function automatic int row_limit();
    if (narrow_mode) begin
      return (tcb_pkg::SMALL_ROWS < ROWS_MAX) ? tcb_pkg::SMALL_ROWS : ROWS_MAX;
    end
    return ROWS_MAX;
  endfunction

  task automatic wipe_cells();
    for (int i = 0; i < ROWS_MAX * COLS_MAX; i++) begin
      shadow_cells[i] = 8'd0;
    end
    cur_col = 0;
    cur_row = 0;
  endtask

  // Line feed: a row past the limit empties the whole screen.
  task automatic next_row(output logic wiped);
    cur_col = 0;
    cur_row = cur_row + 1;
    wiped = 1'b0;
    if (cur_row >= row_limit()) begin
      wipe_cells();
      wiped = 1'b1;
    end
  endtask

  task automatic write_cell(input int row, input int col, input logic [7:0] value);
    if (row < ROWS_MAX && col < COLS_MAX) begin
      shadow_cells[row * COLS_MAX + col] = value;
    end
  endtask

  task automatic step_text_buffer(input logic [1:0] c, input logic [7:0] ch,
                                  input logic [6:0] rr, input logic [6:0] rc,
                                  output cell_result_t res);
    logic       wiped;
    logic [7:0] rd;
    wiped = 1'b0;
    rd    = 8'd0;
    case (c)
      tcb_pkg::CMD_PUT: begin
        if (ch == tcb_pkg::CH_NEWLINE) begin
          next_row(wiped);
        end else if (ch == tcb_pkg::CH_BACKSPACE) begin
          if (cur_col > 0) begin
            cur_col = cur_col - 1;
            write_cell(cur_row, cur_col, 8'd0);
          end
        end else begin
          write_cell(cur_row, cur_col, ch);
          cur_col = cur_col + 1;
          if (cur_col >= col_limit()) begin
            next_row(wiped);
          end
        end
      end
      tcb_pkg::CMD_READ: begin
        if (rr < ROWS_MAX && rc < COLS_MAX) begin
          rd = shadow_cells[int'(rr) * COLS_MAX + int'(rc)];
        end
      end
      tcb_pkg::CMD_CLEAR: begin
        wipe_cells();
        wiped = 1'b1;
      end
      default: begin
      end
    endcase
    res.cell_char      = rd;
    res.cursor_col     = 7'(cur_col);
    res.cursor_row     = 7'(cur_row);
    res.screen_cleared = wiped;
  endtask

  task automatic report_mismatch(input string msg);
    $display("%0d ns: mismatch: %s", $time, msg);
    errors++;
  endtask

  always @(posedge clk) begin : watch_channels
    cell_result_t want;
    cell_result_t fresh;
    if (rst) begin
      wipe_cells();
      narrow_mode = 1'b0;
      expected_results.delete();
    end else begin
      // A result taken now belongs to an item accepted at an earlier edge.
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result transfer with no item outstanding");
        end else begin
          want = expected_results.pop_front();
          if (cell_char !== want.cell_char) begin
            report_mismatch($sformatf("cell_char expected %0d got %0d",
                                      want.cell_char, cell_char));
          end
          if (cursor_col !== want.cursor_col) begin
            report_mismatch($sformatf("cursor_col expected %0d got %0d",
                                      want.cursor_col, cursor_col));
          end
          if (cursor_row !== want.cursor_row) begin
            report_mismatch($sformatf("cursor_row expected %0d got %0d",
                                      want.cursor_row, cursor_row));
          end
          if (screen_cleared !== want.screen_cleared) begin
            report_mismatch($sformatf("screen_cleared expected %0d got %0d",
                                      want.screen_cleared, screen_cleared));
          end
        end
      end
      if (in_valid && in_ready) begin
        step_text_buffer(cmd, char_code, read_row, read_col, fresh);
        expected_results.push_back(fresh);
      end
      if (cfg_we) begin
        narrow_mode = cfg_wdata;
      end
    end
    pending = expected_results.size();
  end

endmodule

@@ tb/text_cell_buffer_cursor_tb.sv @@
`timescale 1ns / 1ps
// Top of the text cell buffer testbench: clock, reset, stimulus and verdict.
// Depends on tcb_pkg, the text_cell_buffer_cursor block and its checker.
module text_cell_buffer_cursor_tb;

  localparam int ROWS_MAX = 75;
  localparam int COLS_MAX = 100;

  // Command code that the block has no meaning for.
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // Values of the one mode register.
  localparam logic MODE_WIDE   = 1'b0;
  localparam logic MODE_NARROW = 1'b1;

  localparam int NUM_PHASES      = 8;
  localparam int ITEMS_PER_PHASE = 156;
  // A clearing pass holds off input while it zeroes every cell, and the
  // receiver may be stalling on top of that, so the drain wait is generous.
  localparam int DRAIN_LIMIT     = 20000;
  localparam int SETTLE_CYCLES   = 16;

  logic       clk;
  logic       rst;
  logic       cfg_we;
  logic       cfg_wdata;
  logic       in_valid;
  logic       in_ready;
  logic [1:0] cmd;
  logic [7:0] char_code;
  logic [6:0] read_row;
  logic [6:0] read_col;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] cell_char;
  logic [6:0] cursor_col;
  logic [6:0] cursor_row;
  logic       screen_cleared;

  int mismatch_count;
  int results_pending;

  // Percentages of cycles in which the sender holds back or the receiver
  // refuses a result; each phase picks its own pair.
  int sender_idle_pct = 0;
  int recv_stall_pct  = 0;
  int phase_items     = 0;

  text_cell_buffer_cursor #(
    .ROWS_MAX(ROWS_MAX),
    .COLS_MAX(COLS_MAX)
  ) DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .cmd           (cmd),
    .char_code     (char_code),
    .read_row      (read_row),
    .read_col      (read_col),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .cell_char     (cell_char),
    .cursor_col    (cursor_col),
    .cursor_row    (cursor_row),
    .screen_cleared(screen_cleared)
  );

  text_cell_buffer_cursor_checker #(
    .ROWS_MAX(ROWS_MAX),
    .COLS_MAX(COLS_MAX)
  ) u_checker (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .cmd            (cmd),
    .char_code      (char_code),
    .read_row       (read_row),
    .read_col       (read_col),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .cell_char      (cell_char),
    .cursor_col     (cursor_col),
    .cursor_row     (cursor_row),
    .screen_cleared (screen_cleared),
    .mismatch_count (mismatch_count),
    .results_pending(results_pending)
  );

  // 10 ns clock, low for the first half period.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // The receiver decides afresh at every falling edge whether it takes a
  // result, so a stall can land on any cycle of the block's work.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Offers one item and returns at the rising edge where its transfer
  // happens. Idle cycles before the item drop valid; once valid is raised it
  // stays up with the payload steady until the block takes the item. The
  // caller's next item is driven at the following falling edge, so valid is
  // assigned only once in any time step.
  task automatic send_item(input logic [1:0] c, input logic [7:0] ch,
                           input logic [6:0] rr, input logic [6:0] rc);
    @(negedge clk);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    cmd       <= c;
    char_code <= ch;
    read_row  <= rr;
    read_col  <= rc;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    phase_items++;
  endtask

  // Drops valid and waits, on falling edges where the checker's count is
  // settled, until every accepted item has had its result taken.
  task automatic wait_drained();
    int guard;
    guard = 0;
    @(negedge clk);
    in_valid <= 1'b0;
    while (results_pending != 0 && guard < DRAIN_LIMIT) begin
      @(negedge clk);
      guard++;
    end
  endtask

  // One random step of the console stream. Most steps are ordinary bytes,
  // with reads, newlines, backspaces and unused codes mixed in; rare runs of
  // printable bytes push the cursor across whole rows and into the column
  // wrap, and full clears are kept rare because each one costs a clearing pass.
  task automatic send_random();
    int         k;
    int         pick;
    int         burst;
    logic [6:0] rr;
    logic [6:0] rc;
    k    = $urandom_range(0, 999);
    pick = $urandom_range(0, 9);
    // Reads lean toward the top rows, which are the ones most often written,
    // but also cover the whole store and addresses outside it.
    if (pick < 5) begin
      rr = 7'($urandom_range(0, 7));
      rc = 7'($urandom_range(0, 49));
    end else if (pick < 9) begin
      rr = 7'($urandom_range(0, ROWS_MAX - 1));
      rc = 7'($urandom_range(0, COLS_MAX - 1));
    end else begin
      rr = 7'($urandom_range(0, 127));
      rc = 7'($urandom_range(0, 127));
    end
    if (k < 10) begin
      send_item(tcb_pkg::CMD_CLEAR, 8'($urandom), rr, rc);
    end else if (k < 30) begin
      send_item(CMD_UNUSED, 8'($urandom), rr, rc);
    end else if (k < 230) begin
      send_item(tcb_pkg::CMD_READ, 8'($urandom), rr, rc);
    end else if (k < 290) begin
      send_item(tcb_pkg::CMD_PUT, tcb_pkg::CH_NEWLINE, rr, rc);
    end else if (k < 350) begin
      send_item(tcb_pkg::CMD_PUT, tcb_pkg::CH_BACKSPACE, rr, rc);
    end else if (k < 353) begin
      burst = $urandom_range(20, 110);
      repeat (burst) begin
        send_item(tcb_pkg::CMD_PUT, 8'($urandom_range(32, 126)),
                  7'($urandom), 7'($urandom));
      end
    end else begin
      send_item(tcb_pkg::CMD_PUT, 8'($urandom), rr, rc);
    end
  endtask

  initial begin
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_wdata = MODE_WIDE;
    in_valid  = 1'b0;
    cmd       = tcb_pkg::CMD_PUT;
    char_code = 8'd0;
    read_row  = 7'd0;
    read_col  = 7'd0;
    out_ready = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed items in the wide mode that reset selects. The first one
    // also waits out the clearing pass that follows reset.
    send_item(tcb_pkg::CMD_READ, 8'd0, 7'd0, 7'd0);          // empty store reads zero
    send_item(tcb_pkg::CMD_PUT, 8'd0, 7'd0, 7'd0);           // byte zero still advances
    send_item(tcb_pkg::CMD_PUT, 8'hFF, 7'd127, 7'd127);      // largest byte
    send_item(tcb_pkg::CMD_PUT, 8'h41, 7'd0, 7'd0);
    send_item(tcb_pkg::CMD_READ, 8'd0, 7'd0, 7'd1);
    send_item(tcb_pkg::CMD_READ, 8'hFF, 7'd0, 7'd0);
    send_item(tcb_pkg::CMD_PUT, tcb_pkg::CH_BACKSPACE, 7'd0, 7'd0);  // steps back, zeroes
    send_item(tcb_pkg::CMD_READ, 8'd0, 7'd0, 7'd2);
    send_item(tcb_pkg::CMD_PUT, tcb_pkg::CH_NEWLINE, 7'd0, 7'd0);
    send_item(tcb_pkg::CMD_PUT, tcb_pkg::CH_BACKSPACE, 7'd0, 7'd0);  // column 0: no effect
    send_item(CMD_UNUSED, 8'hFF, 7'd127, 7'd127);            // unused command
    send_item(tcb_pkg::CMD_READ, 8'd0, 7'(ROWS_MAX - 1), 7'(COLS_MAX - 1));
    send_item(tcb_pkg::CMD_READ, 8'd0, 7'(ROWS_MAX), 7'd0);  // row outside the store
    send_item(tcb_pkg::CMD_READ, 8'd0, 7'd0, 7'(COLS_MAX));  // column outside the store
    send_item(tcb_pkg::CMD_READ, 8'd0, 7'd127, 7'd127);
    send_item(tcb_pkg::CMD_PUT, 8'h7E, 7'd0, 7'd0);
    send_item(tcb_pkg::CMD_CLEAR, 8'hFF, 7'd127, 7'd127);
    send_item(tcb_pkg::CMD_READ, 8'd0, 7'd1, 7'd0);          // cleared cells read zero
    send_item(tcb_pkg::CMD_READ, 8'd0, 7'd0, 7'd1);
    send_item(tcb_pkg::CMD_PUT, tcb_pkg::CH_NEWLINE, 7'd0, 7'd0);
    wait_drained();

    // Random phases. Even phases use the wide mode and sometimes start with
    // a clear; odd phases switch to the narrow mode without one, so the
    // cursor left by the wide phase may sit past the narrow limits.
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p % 4)
        0: begin
          sender_idle_pct = 0;
          recv_stall_pct  = 0;
        end
        1: begin
          sender_idle_pct = 87;
          recv_stall_pct  = 0;
        end
        2: begin
          sender_idle_pct = 0;
          recv_stall_pct  = 87;
        end
        default: begin
          sender_idle_pct = 18;
          recv_stall_pct  = 18;
        end
      endcase
      // Mode writes happen only with nothing outstanding.
      @(negedge clk);
      cfg_wdata <= (p % 2 == 1) ? MODE_NARROW : MODE_WIDE;
      cfg_we    <= 1'b1;
      @(negedge clk);
      cfg_we    <= 1'b0;
      if (p % 2 == 0 && $urandom_range(0, 1) == 1) begin
        send_item(tcb_pkg::CMD_CLEAR, 8'd0, 7'd0, 7'd0);
      end
      phase_items = 0;
      while (phase_items < ITEMS_PER_PHASE) begin
        send_random();
      end
      wait_drained();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && results_pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run, clearing passes included.
  initial begin
    #40_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
